[rtl/assert_macros.svh]
// Assertion helpers shared by the lock RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)

`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

[rtl/pccl_pkg.sv]
package pccl_pkg;

    localparam int TIMEOUT_W = 16;
    localparam int COUNT_W   = 4;
    localparam int PHASE_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int DIGITS    = 3;

    localparam logic [PHASE_W-1:0] PHASE_IDLE   = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_FIRST  = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_SECOND = 2'd2;
    localparam logic [PHASE_W-1:0] PHASE_THIRD  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_FIRST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_SECOND = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_THIRD  = 2'd3;

    localparam logic [COUNT_W-1:0] ZERO_COUNT = 4'd10;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 4'd15;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [COUNT_W-1:0]   CODE_FIRST_RESET  = 4'd5;
    localparam logic [COUNT_W-1:0]   CODE_SECOND_RESET = 4'd2;
    localparam logic [COUNT_W-1:0]   CODE_THIRD_RESET  = 4'd6;

    typedef struct packed {
        logic                 alarm_on;
        logic [PHASE_W-1:0]   entry_phase;
    } result_t;

    typedef struct packed {
        logic                 wr_en;
        logic [CFG_IDX_W-1:0] index;
        logic [TIMEOUT_W-1:0] data;
    } cfg_wr_t;

endpackage

[rtl/pccl_core.sv]
`include "assert_macros.svh"

module pccl_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  pccl_pkg::cfg_wr_t  cfg,
    input  logic               tick_en,
    input  logic               button_pressed,
    output pccl_pkg::result_t  result
);

    logic [pccl_pkg::TIMEOUT_W-1:0] timeout_reg;
    logic [pccl_pkg::COUNT_W-1:0]   code_reg [pccl_pkg::DIGITS];

    logic [pccl_pkg::PHASE_W-1:0]   phase_reg, phase_next;
    logic [pccl_pkg::COUNT_W-1:0]   counts_reg [pccl_pkg::DIGITS];
    logic [pccl_pkg::COUNT_W-1:0]   counts_next [pccl_pkg::DIGITS];
    logic [pccl_pkg::TIMEOUT_W-1:0] countdown_reg, countdown_next;
    logic                           alarm_reg, alarm_next;

    logic [1:0]                     slot;
    logic [pccl_pkg::COUNT_W-1:0]   cur_count;
    logic [pccl_pkg::COUNT_W-1:0]   cur_inc;
    logic [pccl_pkg::TIMEOUT_W-1:0] cd_dec;
    logic                           code_match;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= pccl_pkg::TIMEOUT_RESET;
            code_reg[0] <= pccl_pkg::CODE_FIRST_RESET;
            code_reg[1] <= pccl_pkg::CODE_SECOND_RESET;
            code_reg[2] <= pccl_pkg::CODE_THIRD_RESET;
        end else if (cfg.wr_en) begin
            unique case (cfg.index)
                pccl_pkg::REG_TIMEOUT:     timeout_reg <= cfg.data;
                pccl_pkg::REG_CODE_FIRST:  code_reg[0] <= cfg.data[pccl_pkg::COUNT_W-1:0];
                pccl_pkg::REG_CODE_SECOND: code_reg[1] <= cfg.data[pccl_pkg::COUNT_W-1:0];
                pccl_pkg::REG_CODE_THIRD:  code_reg[2] <= cfg.data[pccl_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (phase_reg)
            pccl_pkg::PHASE_SECOND: slot = 2'd1;
            pccl_pkg::PHASE_THIRD:  slot = 2'd2;
            default:                slot = 2'd0;
        endcase
    end

    assign cur_count  = counts_reg[slot];
    assign cur_inc    = (cur_count < pccl_pkg::COUNT_MAX) ?
                        cur_count + pccl_pkg::COUNT_W'(1) : cur_count;
    assign cd_dec     = (countdown_reg != '0) ?
                        countdown_reg - pccl_pkg::TIMEOUT_W'(1) : '0;
    assign code_match = (counts_reg[0] == code_reg[0]) &&
                        (counts_reg[1] == code_reg[1]) &&
                        (counts_reg[2] == code_reg[2]);

    always_comb begin
        phase_next     = phase_reg;
        countdown_next = countdown_reg;
        alarm_next     = alarm_reg;
        for (int i = 0; i < pccl_pkg::DIGITS; i++) begin
            counts_next[i] = counts_reg[i];
        end
        if (button_pressed) begin
            counts_next[slot] = cur_inc;
            countdown_next    = timeout_reg;
            if (phase_reg == pccl_pkg::PHASE_IDLE) begin
                phase_next = pccl_pkg::PHASE_FIRST;
            end
        end else if (phase_reg != pccl_pkg::PHASE_IDLE) begin
            countdown_next = cd_dec;
            if (cd_dec == '0 || cur_count == pccl_pkg::ZERO_COUNT) begin
                if (phase_reg == pccl_pkg::PHASE_THIRD) begin
                    alarm_next = alarm_reg ^ code_match;
                    phase_next = pccl_pkg::PHASE_IDLE;
                    for (int i = 0; i < pccl_pkg::DIGITS; i++) begin
                        counts_next[i] = '0;
                    end
                end else begin
                    phase_next = phase_reg + pccl_pkg::PHASE_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= pccl_pkg::PHASE_IDLE;
            countdown_reg <= '0;
            alarm_reg     <= 1'b0;
            for (int i = 0; i < pccl_pkg::DIGITS; i++) begin
                counts_reg[i] <= '0;
            end
        end else if (tick_en) begin
            phase_reg     <= phase_next;
            countdown_reg <= countdown_next;
            alarm_reg     <= alarm_next;
            for (int i = 0; i < pccl_pkg::DIGITS; i++) begin
                counts_reg[i] <= counts_next[i];
            end
        end
    end

    // result reflects the state after this tick
    assign result.alarm_on    = alarm_next;
    assign result.entry_phase = phase_next;

    `ASSERT_PROP(a_idle_clear, aclk, aresetn, (phase_reg == pccl_pkg::PHASE_IDLE) |-> (counts_reg[0] == '0 && counts_reg[1] == '0 && counts_reg[2] == '0))
    `ASSERT_PROP(a_first_only, aclk, aresetn, (phase_reg == pccl_pkg::PHASE_FIRST) |-> (counts_reg[0] != '0 && counts_reg[1] == '0 && counts_reg[2] == '0))
    `ASSERT_PROP(a_alarm_on_check, aclk, aresetn, (alarm_reg != $past(alarm_reg)) |-> ($past(phase_reg) == pccl_pkg::PHASE_THIRD && phase_reg == pccl_pkg::PHASE_IDLE))

endmodule

[rtl/pccl_out_buf.sv]
`include "assert_macros.svh"

module pccl_out_buf (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  pccl_pkg::result_t  push_data,
    output logic               can_push,
    output logic               out_valid,
    input  logic               out_ready,
    output pccl_pkg::result_t  out_data
);

    logic              out_valid_reg;
    logic              skid_valid_reg;
    pccl_pkg::result_t out_data_reg;
    pccl_pkg::result_t skid_data_reg;
    logic              pop;

    assign pop      = out_valid_reg && out_ready;
    assign can_push = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else if (push) begin
                out_data_reg <= push_data;
            end
        end else if (push) begin
            skid_data_reg <= push_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `ASSERT_NEVER(a_skid_without_out, aclk, aresetn, skid_valid_reg && !out_valid_reg)
    `ASSERT_PROP(a_skid_holds, aclk, aresetn, (skid_valid_reg && !pop) |=> (skid_valid_reg && $stable(skid_data_reg)))
    `ASSERT_NEVER(a_push_when_full, aclk, aresetn, push && skid_valid_reg)

endmodule

[rtl/press_count_code_lock.sv]
// Three-digit press-count combination lock. Each accepted s_ request is one
// tick carrying a latched button-press flag; every tick returns exactly one
// m_ request with the alarm state and the entry phase after that tick. A
// digit is entered by pressing that many times (ten presses mean zero); a
// digit ends after timeout_ticks ticks without a press or at a count of ten.
// After the third digit the counts are checked against the code and the
// alarm toggles on a match. The tick update is combinational, so a tick is
// accepted every cycle while s_tready is high; a two-deep output register
// keeps ticks flowing while a result waits, and s_tready drops only when
// both stages hold results. Configuration writes (cfg_index 0 timeout, 1 to
// 3 code digits) take effect at the next edge and must be made only while
// the block is idle; the block itself does not enforce this.
module press_count_code_lock (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [0] button_pressed
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [0] alarm_on, [2:1] entry_phase
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wr_data
);

    pccl_pkg::cfg_wr_t cfg;
    pccl_pkg::result_t tick_result;
    pccl_pkg::result_t out_result;
    logic              tick_en;

    assign cfg.wr_en = cfg_wr_en;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_wr_data;

    assign tick_en = s_tvalid && s_tready;

    pccl_core u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .tick_en        (tick_en),
        .button_pressed (s_tdata[0]),
        .result         (tick_result)
    );

    pccl_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (tick_en),
        .push_data (tick_result),
        .can_push  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = {5'd0, out_result.entry_phase, out_result.alarm_on};

endmodule
